### src/rcs_pkg.sv
package rcs_pkg;

  localparam int unsigned ANGLE_FRAC_BITS_DEF = 6;
  localparam int unsigned HEAD_FRAC = 22;

  localparam int unsigned AW = 56;
  localparam int unsigned BW = 34;
  localparam int unsigned NW = 6;

  localparam logic [12:0] AXIS_DIV = 13'd1000;
  localparam logic [12:0] YAW_DIV = 13'd5000;
  localparam logic [22:0] HEAD_DIV = 23'd5000000;
  localparam logic signed [33:0] HALF_TURN = 34'sd754974720;
  localparam logic [16:0] Q16_ONE = 17'd65536;
  localparam logic [16:0] EXPO_FLOOR = 17'd656;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } rcs_op_e;

  typedef enum logic [2:0] {
    CFG_HOVER,
    CFG_EXPO,
    CFG_ANGLE,
    CFG_RATE,
    CFG_TMIN,
    CFG_TMAX
  } rcs_cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LIM5,
    S_AX_MUL,
    S_AX_DIV,
    S_TH_DIV,
    S_TH_SQRT,
    S_TH_SQ,
    S_TH_CUBE,
    S_TH_M1,
    S_TH_M2,
    S_TH_M3,
    S_TH_M4,
    S_HD_MUL,
    S_HD_DIV,
    S_DONE
  } rcs_state_e;

  typedef struct packed {
    logic          start;
    rcs_op_e       op;
    logic [AW-1:0] a;
    logic [BW-1:0] b;
    logic [NW-1:0] n;
  } rcs_req_t;

  typedef struct packed {
    logic          done;
    logic [AW-1:0] res;
  } rcs_rsp_t;

endpackage

### src/rcs_serial.sv
module rcs_serial (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rcs_pkg::rcs_req_t req_i,
  output rcs_pkg::rcs_rsp_t rsp_o
);
  import rcs_pkg::*;

  logic          busy_q, done_q;
  rcs_op_e       op_q;
  logic [NW-1:0] cnt_q, cnt_m1;
  logic [AW-1:0] acc_q, acc_d, opa_q, opa_d;
  logic [BW-1:0] opb_q, opb_d;
  logic [BW:0]   rem_q, rem_d, trial, cmpb;
  logic          ge;

  assign cnt_m1 = cnt_q - NW'(1);

  always_comb begin
    trial = rem_q;
    cmpb  = {1'b0, opb_q};
    acc_d = acc_q;
    opa_d = opa_q;
    opb_d = opb_q;
    case (op_q)
      OP_DIV: begin
        trial = {rem_q[BW-1:0], opa_q[cnt_m1]};
        cmpb  = {1'b0, opb_q};
      end
      OP_SQRT: begin
        trial = {rem_q[BW-2:0], opa_q[{cnt_m1[NW-2:0], 1'b0} +: 2]};
        cmpb  = {acc_q[BW-2:0], 2'b01};
      end
      default: ;
    endcase
    ge    = (trial >= cmpb);
    rem_d = ge ? (trial - cmpb) : trial;
    if (op_q == OP_MUL) begin
      if (opb_q[0]) acc_d = acc_q + opa_q;
      opa_d = {opa_q[AW-2:0], 1'b0};
      opb_d = {1'b0, opb_q[BW-1:1]};
      rem_d = rem_q;
    end else begin
      acc_d = {acc_q[AW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= busy_q && (cnt_q == NW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.n;
        op_q   <= req_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_m1;
        if (cnt_q == NW'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      opa_q <= req_i.a;
      opb_q <= req_i.b;
      rem_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      opa_q <= opa_d;
      opb_q <= opb_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;

endmodule

### src/rc_stick_to_setpoint_unit.sv
// A word with a lost channel skips all arithmetic; a word that is flying with a nonzero
// thrust span runs the longest path.
// Throughput: one word at a time; the next word is taken while the result waits.
// The arithmetic runs on the shared bit-serial multiply/divide/sqrt unit (one bit
// or bit pair per cycle, 21 operations per word).
// Reset: asynchronous, active low; config registers at their defaults, held setpoints zero.
module rc_stick_to_setpoint_unit #(
  parameter int unsigned ANGLE_FRAC_BITS = rcs_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [16:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [11:0]        roll_pulse_i,
  input  logic [11:0]        pitch_pulse_i,
  input  logic [11:0]        yaw_pulse_i,
  input  logic [11:0]        thrust_pulse_i,
  input  logic               is_flying_i,
  input  logic [15:0]        elapsed_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               signal_lost_o,
  output logic [9:0]         thrust_cmd_o,
  output logic signed [17:0] roll_angle_o,
  output logic signed [17:0] pitch_angle_o,
  output logic signed [14:0] yaw_heading_o,
  output logic signed [17:0] roll_rate_o,
  output logic signed [17:0] pitch_rate_o,
  output logic signed [17:0] yaw_rate_o
);
  import rcs_pkg::*;

  localparam int unsigned ADZ = 1 << ANGLE_FRAC_BITS;
  localparam int unsigned RDZ = 4 << ANGLE_FRAC_BITS;
  localparam int unsigned HSH = HEAD_FRAC - ANGLE_FRAC_BITS;
  localparam longint unsigned HRND = (64'd1 << HSH) - 64'd1;

  rcs_state_e state_q, state_d;
  logic [2:0] k_q, k_d;
  logic       issue_q, issue_d;
  rcs_req_t   req;
  rcs_rsp_t   rsp;

  logic [15:0] hover_q, expo_q;
  logic [16:0] alim_q, rlim_q;
  logic [11:0] tmin_q, tmax_q;

  logic [11:0] roll_q, pitch_q, yaw_q, thr_q;
  logic        fly_q, lost_q;
  logic [15:0] dt_q;

  logic signed [31:0] acc_q;
  logic [9:0]  hthr_q;
  logic [17:0] hang_q [2];
  logic [17:0] hrate_q [3];
  logic [16:0] rl5_q, r_q, lin_q, cube_q, ex_q, out_q;
  logic [33:0] t1_q;

  logic        out_valid_q, out_load;
  logic        o_lost_q;
  logic [9:0]  o_thr_q;
  logic [17:0] o_ra_q, o_pa_q, o_rr_q, o_pr_q, o_yr_q;
  logic [14:0] o_hd_q;

  logic lost_in;
  assign lost_in = (roll_pulse_i == '0) || (pitch_pulse_i == '0) ||
                   (yaw_pulse_i == '0) || (thrust_pulse_i == '0);

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hover_q <= '0;
      expo_q  <= '0;
      alim_q  <= 17'd1920;
      rlim_q  <= 17'd12800;
      tmin_q  <= 12'd1070;
      tmax_q  <= 12'd1941;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HOVER: hover_q <= cfg_wdata_i[15:0];
        CFG_EXPO:  expo_q  <= cfg_wdata_i[15:0];
        CFG_ANGLE: alim_q  <= cfg_wdata_i;
        CFG_RATE:  rlim_q  <= cfg_wdata_i;
        CFG_TMIN:  tmin_q  <= cfg_wdata_i[11:0];
        CFG_TMAX:  tmax_q  <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // axis select
  logic [11:0] ax_pulse;
  logic [16:0] ax_amp, ax_lim, ax_cl;
  logic [12:0] ax_div, ax_xmag;
  logic [29:0] ax_dz, ax_q, ax_vm;
  logic        ax_inv, ax_xneg;
  logic signed [13:0] ax_x;
  logic [17:0] ax_val;

  always_comb begin
    case (k_q)
      3'd0: begin
        ax_pulse = roll_q; ax_amp = alim_q; ax_div = AXIS_DIV; ax_lim = alim_q;
        ax_dz = 30'(ADZ); ax_inv = 1'b1;
      end
      3'd1: begin
        ax_pulse = pitch_q; ax_amp = alim_q; ax_div = AXIS_DIV; ax_lim = alim_q;
        ax_dz = 30'(ADZ); ax_inv = 1'b0;
      end
      3'd2: begin
        ax_pulse = roll_q; ax_amp = rlim_q; ax_div = AXIS_DIV; ax_lim = rlim_q;
        ax_dz = 30'(RDZ); ax_inv = 1'b1;
      end
      3'd3: begin
        ax_pulse = pitch_q; ax_amp = rlim_q; ax_div = AXIS_DIV; ax_lim = rlim_q;
        ax_dz = 30'(RDZ); ax_inv = 1'b0;
      end
      default: begin
        ax_pulse = yaw_q; ax_amp = rlim_q; ax_div = YAW_DIV; ax_lim = rl5_q;
        ax_dz = 30'(RDZ); ax_inv = 1'b1;
      end
    endcase
  end

  assign ax_x    = $signed({1'b0, ax_pulse, 1'b0}) - 14'sd3000;
  assign ax_xneg = ax_x[13];
  assign ax_xmag = ax_xneg ? 13'(-ax_x) : 13'(ax_x);
  assign ax_q    = rsp.res[29:0];
  assign ax_vm   = (ax_q < ax_dz) ? '0 : (ax_q - ax_dz);
  assign ax_cl   = (ax_vm > {13'd0, ax_lim}) ? ax_lim : ax_vm[16:0];
  assign ax_val  = (ax_xneg ^ ax_inv) ? (18'd0 - {1'b0, ax_cl}) : {1'b0, ax_cl};

  // throttle operands
  logic signed [12:0] th_num, th_den, th_nn;
  logic [11:0] th_dabs, th_nabs;
  logic        th_pos, th_dz0;
  logic [34:0] th_exsum;
  logic [17:0] th_out;

  assign th_num  = $signed({1'b0, thr_q}) - $signed({1'b0, tmin_q});
  assign th_den  = $signed({1'b0, tmax_q}) - $signed({1'b0, tmin_q});
  assign th_dz0  = (th_den == '0);
  assign th_nn   = th_den[12] ? -th_num : th_num;
  assign th_dabs = th_den[12] ? 12'(-th_den) : 12'(th_den);
  assign th_pos  = !th_nn[12] && (th_nn != '0);
  assign th_nabs = th_nn[11:0];
  assign th_exsum = {1'b0, t1_q} + {1'b0, rsp.res[33:0]};
  assign th_out  = {2'b00, hover_q} + {1'b0, rsp.res[32:16]};

  // heading operands
  logic signed [12:0] hd_t;
  logic [12:0] hd_tm;
  logic [11:0] hd_tmag;
  logic        hd_neg;
  logic signed [33:0] hd_sum, hd_wrap;

  assign hd_t    = 13'sd1500 - $signed({1'b0, yaw_q});
  assign hd_neg  = hd_t[12];
  assign hd_tm   = hd_neg ? 13'(-hd_t) : 13'(hd_t);
  assign hd_tmag = (hd_tm < 13'd50) ? '0 : 12'(hd_tm - 13'd50);
  assign hd_sum  = hd_neg ? ($signed({{2{acc_q[31]}}, acc_q}) - $signed({5'd0, rsp.res[28:0]}))
                          : ($signed({{2{acc_q[31]}}, acc_q}) + $signed({5'd0, rsp.res[28:0]}));
  always_comb begin
    if (hd_sum > HALF_TURN) hd_wrap = hd_sum - (HALF_TURN + HALF_TURN);
    else if (hd_sum < -HALF_TURN) hd_wrap = hd_sum + (HALF_TURN + HALF_TURN);
    else hd_wrap = hd_sum;
  end

  logic signed [32:0] hd_adj, hd_sh;
  assign hd_adj = $signed({acc_q[31], acc_q}) + (acc_q[31] ? $signed(33'(HRND)) : 33'sd0);
  assign hd_sh  = hd_adj >>> HSH;

  // next state
  rcs_state_e th_next, hd_next;
  assign hd_next = fly_q ? S_HD_MUL : S_DONE;
  assign th_next = th_dz0 ? hd_next : S_TH_DIV;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      S_IDLE: begin
        k_d = '0;
        if (in_valid_i) state_d = lost_in ? S_DONE : S_LIM5;
      end
      S_LIM5:    if (rsp.done) state_d = S_AX_MUL;
      S_AX_MUL:  if (rsp.done) state_d = S_AX_DIV;
      S_AX_DIV: begin
        if (rsp.done) begin
          if (k_q == 3'd4) state_d = th_next;
          else begin
            state_d = S_AX_MUL;
            k_d     = k_q + 3'd1;
          end
        end
      end
      S_TH_DIV:  if (rsp.done) state_d = S_TH_SQRT;
      S_TH_SQRT: if (rsp.done) state_d = S_TH_SQ;
      S_TH_SQ:   if (rsp.done) state_d = S_TH_CUBE;
      S_TH_CUBE: if (rsp.done) state_d = S_TH_M1;
      S_TH_M1:   if (rsp.done) state_d = S_TH_M2;
      S_TH_M2:   if (rsp.done) state_d = S_TH_M3;
      S_TH_M3:   if (rsp.done) state_d = S_TH_M4;
      S_TH_M4:   if (rsp.done) state_d = hd_next;
      S_HD_MUL:  if (rsp.done) state_d = S_HD_DIV;
      S_HD_DIV:  if (rsp.done) state_d = S_DONE;
      S_DONE:    if (out_load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  assign issue_d = (state_d != state_q) && (state_d != S_IDLE) && (state_d != S_DONE);

  // unit requests
  always_comb begin
    req.start = issue_q;
    req.op    = OP_MUL;
    req.a     = '0;
    req.b     = '0;
    req.n     = NW'(17);
    unique case (state_q)
      S_LIM5: begin
        req.op = OP_DIV; req.a = AW'(rlim_q); req.b = BW'(3'd5);
      end
      S_AX_MUL: begin
        req.a = AW'(ax_amp); req.b = BW'(ax_xmag);
      end
      S_AX_DIV: begin
        req.op = OP_DIV; req.a = rsp.res; req.b = BW'(ax_div); req.n = NW'(30);
      end
      S_TH_DIV: begin
        req.op = OP_DIV; req.a = AW'({th_nabs, 16'd0}); req.b = BW'(th_dabs);
        req.n = NW'(28);
      end
      S_TH_SQRT: begin
        req.op = OP_SQRT; req.a = AW'({r_q, 16'd0});
      end
      S_TH_SQ:   begin req.a = AW'(lin_q); req.b = BW'(lin_q); end
      S_TH_CUBE: begin req.a = rsp.res; req.b = BW'(lin_q); end
      S_TH_M1: begin
        req.a = AW'(Q16_ONE - {1'b0, expo_q}); req.b = BW'(lin_q);
      end
      S_TH_M2:   begin req.a = AW'(expo_q); req.b = BW'(cube_q); end
      S_TH_M3: begin
        req.a = AW'(ex_q); req.b = BW'(Q16_ONE - {1'b0, hover_q});
      end
      S_TH_M4:   begin req.a = AW'(out_q); req.b = BW'(10'd1000); end
      S_HD_MUL:  begin req.a = AW'(hd_tmag); req.b = BW'(dt_q); end
      S_HD_DIV: begin
        req.op = OP_DIV; req.a = AW'({rsp.res[27:0], 23'd0}); req.b = BW'(HEAD_DIV);
        req.n = NW'(51);
      end
      default: ;
    endcase
  end

  rcs_serial u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      issue_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      issue_q <= issue_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      roll_q  <= roll_pulse_i;
      pitch_q <= pitch_pulse_i;
      yaw_q   <= yaw_pulse_i;
      thr_q   <= thrust_pulse_i;
      fly_q   <= is_flying_i;
      dt_q    <= elapsed_us_i;
      lost_q  <= lost_in;
    end
    if (rsp.done) begin
      unique case (state_q)
        S_LIM5:    rl5_q  <= rsp.res[16:0];
        S_TH_DIV: begin
          if (!th_pos) r_q <= '0;
          else if (th_nabs >= th_dabs) r_q <= Q16_ONE;
          else r_q <= rsp.res[16:0];
        end
        S_TH_SQRT: lin_q  <= rsp.res[16:0];
        S_TH_CUBE: cube_q <= rsp.res[48:32];
        S_TH_M1:   t1_q   <= rsp.res[33:0];
        S_TH_M2:   ex_q   <= th_exsum[32:16];
        S_TH_M3:   out_q  <= (th_out > {1'b0, Q16_ONE}) ? Q16_ONE : th_out[16:0];
        default: ;
      endcase
    end
  end

  // held setpoints
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      hthr_q   <= '0;
      hang_q   <= '{default: '0};
      hrate_q  <= '{default: '0};
    end else if (rsp.done) begin
      unique case (state_q)
        S_AX_DIV: begin
          case (k_q)
            3'd0:    hang_q[0]  <= ax_val;
            3'd1:    hang_q[1]  <= ax_val;
            3'd2:    hrate_q[0] <= ax_val;
            3'd3:    hrate_q[1] <= ax_val;
            default: hrate_q[2] <= ax_val;
          endcase
          if ((k_q == 3'd4) && th_dz0) hthr_q <= '0;
        end
        S_TH_M4:  hthr_q <= (ex_q < EXPO_FLOOR) ? '0 : rsp.res[25:16];
        S_HD_DIV: acc_q  <= hd_wrap[31:0];
        default: ;
      endcase
    end
  end

  // output word
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_lost_q <= lost_q;
      o_thr_q  <= hthr_q;
      o_ra_q   <= hang_q[0];
      o_pa_q   <= hang_q[1];
      o_hd_q   <= hd_sh[14:0];
      o_rr_q   <= hrate_q[0];
      o_pr_q   <= hrate_q[1];
      o_yr_q   <= hrate_q[2];
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign signal_lost_o = o_lost_q;
  assign thrust_cmd_o  = o_thr_q;
  assign roll_angle_o  = $signed(o_ra_q);
  assign pitch_angle_o = $signed(o_pa_q);
  assign yaw_heading_o = $signed(o_hd_q);
  assign roll_rate_o   = $signed(o_rr_q);
  assign pitch_rate_o  = $signed(o_pr_q);
  assign yaw_rate_o    = $signed(o_yr_q);

endmodule

### src/rcs_checker.sv
module rcs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [9:0]         thrust_cmd_o,
  input logic signed [14:0] yaw_heading_o,
  input logic signed [17:0] roll_angle_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(thrust_cmd_o) &&
    $stable(roll_angle_o) && $stable(yaw_heading_o))
    else $error("result word changed while stalled");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while busy");

  a_thr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> thrust_cmd_o <= 10'd1000)
    else $error("thrust command out of range");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (yaw_heading_o <= 15'sd11520) && (yaw_heading_o >= -15'sd11520))
    else $error("heading out of range");

endmodule

bind rc_stick_to_setpoint_unit rcs_checker u_rcs_checker (.*);
